// File: src/bir_pkg.sv
// shared constants and types of the bilinear image resampler
package bir_pkg;

    localparam int DIM_W    = 9;
    localparam int STEP_W   = 24;
    localparam int COORD_W  = 12;
    localparam int INDEX_W  = 16;
    localparam int PIX_W    = 32;
    localparam int POS_FRAC = 16;
    localparam int POS_W    = COORD_W + STEP_W;
    localparam int IP_W     = POS_W - POS_FRAC;
    localparam int STORE_DEPTH = 65536;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 24;
    localparam int CHAN_W      = 8;
    localparam int NUM_CHAN    = 4;

    localparam int DEF_MAX_WIDTH  = 256;
    localparam int DEF_MAX_HEIGHT = 256;
    localparam int DEF_FRAC_BITS  = 8;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_X_STEP     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_STEP     = 2'd3;

    localparam logic [DIM_W-1:0]  RST_SRC_WIDTH  = 9'd256;
    localparam logic [DIM_W-1:0]  RST_SRC_HEIGHT = 9'd256;
    localparam logic [STEP_W-1:0] RST_STEP       = 24'd65536;

    // control bits that travel with each item down the pipeline
    typedef struct packed {
        logic valid;
        logic wr;
    } bir_ctl_t;

endpackage

// File: src/bir_if.sv
// item channel interfaces of the resampler
interface bir_req_if;
    logic                          valid;
    logic                          ready;
    logic                          func;
    logic [bir_pkg::INDEX_W-1:0]   pixel_index;
    logic [bir_pkg::PIX_W-1:0]     pixel_value;
    logic [bir_pkg::COORD_W-1:0]   dst_x;
    logic [bir_pkg::COORD_W-1:0]   dst_y;

    modport source (output valid, func, pixel_index, pixel_value, dst_x, dst_y, input ready);
    modport sink (input valid, func, pixel_index, pixel_value, dst_x, dst_y, output ready);
endinterface

interface bir_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [bir_pkg::PIX_W-1:0] pixel_out;

    modport source (output valid, pixel_out, input ready);
    modport sink (input valid, pixel_out, output ready);
endinterface

// File: src/bir_ram.sv
// generic single write, single read ram with registered read data
module bir_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/bir_addr.sv
// position, clamp, weight and neighbor address stages
module bir_addr #(
    parameter int MAX_WIDTH  = bir_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bir_pkg::DEF_MAX_HEIGHT,
    parameter int FRAC_BITS  = bir_pkg::DEF_FRAC_BITS
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         adv,
    input  bir_pkg::bir_ctl_t            in_ctl,
    input  logic [bir_pkg::INDEX_W-1:0]  pixel_index,
    input  logic [bir_pkg::PIX_W-1:0]    pixel_value,
    input  logic [bir_pkg::COORD_W-1:0]  dst_x,
    input  logic [bir_pkg::COORD_W-1:0]  dst_y,
    input  logic [bir_pkg::DIM_W-1:0]    src_width,
    input  logic [bir_pkg::DIM_W-1:0]    src_height,
    input  logic [bir_pkg::STEP_W-1:0]   x_step,
    input  logic [bir_pkg::STEP_W-1:0]   y_step,
    output bir_pkg::bir_ctl_t            out_ctl,
    output logic [bir_pkg::INDEX_W-1:0]  waddr,
    output logic [bir_pkg::PIX_W-1:0]    wdata,
    output logic [bir_pkg::INDEX_W-1:0]  a_ul,
    output logic [bir_pkg::INDEX_W-1:0]  a_ur,
    output logic [bir_pkg::INDEX_W-1:0]  a_bl,
    output logic [bir_pkg::INDEX_W-1:0]  a_br,
    output logic [2*FRAC_BITS:0]         w_ul,
    output logic [2*FRAC_BITS:0]         w_ur,
    output logic [2*FRAC_BITS:0]         w_bl,
    output logic [2*FRAC_BITS:0]         w_br
);

    localparam int DW = bir_pkg::DIM_W;
    localparam int AW = bir_pkg::INDEX_W;
    localparam int WW = 2 * FRAC_BITS + 1;
    localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS + 1)'(1) << FRAC_BITS;

    logic [DW-1:0] w_dim;
    logic [DW-1:0] h_dim;

    // effective frame size: zero acts as one, capped at the maximum
    always_comb
    begin
        if (src_width == '0)
            w_dim = DW'(1);
        else if (32'(src_width) > MAX_WIDTH)
            w_dim = DW'(MAX_WIDTH);
        else
            w_dim = src_width;
        if (src_height == '0)
            h_dim = DW'(1);
        else if (32'(src_height) > MAX_HEIGHT)
            h_dim = DW'(MAX_HEIGHT);
        else
            h_dim = src_height;
    end

    bir_pkg::bir_ctl_t s1_ctl_reg, s2_ctl_reg, s3_ctl_reg, s4_ctl_reg;
    logic [AW-1:0]    s1_idx_reg, s2_idx_reg, s3_idx_reg, s4_idx_reg;
    logic [bir_pkg::PIX_W-1:0] s1_val_reg, s2_val_reg, s3_val_reg, s4_val_reg;

    logic [bir_pkg::POS_W-1:0] s1_px_reg, s1_py_reg;

    logic [DW-1:0]        s2_xi_reg, s2_yi_reg;
    logic [FRAC_BITS-1:0] s2_fx_reg, s2_fy_reg;
    logic                 s2_hr_reg, s2_hb_reg;

    logic [AW-1:0]        s3_base_reg;
    logic [DW-1:0]        s3_xi_reg;
    logic                 s3_hr_reg, s3_hb_reg;
    logic [WW-1:0]        s3_wul_reg, s3_wur_reg, s3_wbl_reg, s3_wbr_reg;

    logic [AW-1:0]        s4_ul_reg, s4_ur_reg, s4_bl_reg, s4_br_reg;
    logic [WW-1:0]        s4_wul_reg, s4_wur_reg, s4_wbl_reg, s4_wbr_reg;

    // stage 2 split of the positions
    logic [bir_pkg::IP_W-1:0] ipx, ipy;
    logic [DW-1:0]            xi_next, yi_next;
    logic [FRAC_BITS-1:0]     fx_next, fy_next;

    always_comb
    begin
        ipx = s1_px_reg[bir_pkg::POS_W-1:bir_pkg::POS_FRAC];
        ipy = s1_py_reg[bir_pkg::POS_W-1:bir_pkg::POS_FRAC];
        if (ipx >= bir_pkg::IP_W'(w_dim - DW'(1)))
        begin
            xi_next = w_dim - DW'(1);
            fx_next = '0;
        end
        else
        begin
            xi_next = ipx[DW-1:0];
            fx_next = s1_px_reg[bir_pkg::POS_FRAC-1 -: FRAC_BITS];
        end
        if (ipy >= bir_pkg::IP_W'(h_dim - DW'(1)))
        begin
            yi_next = h_dim - DW'(1);
            fy_next = '0;
        end
        else
        begin
            yi_next = ipy[DW-1:0];
            fy_next = s1_py_reg[bir_pkg::POS_FRAC-1 -: FRAC_BITS];
        end
    end

    // stage 3 weights and row base
    logic [FRAC_BITS:0]  sx, sy;
    logic [2*DW-1:0]     base_full;
    logic [2*FRAC_BITS+1:0] p_ul, p_ur, p_bl, p_br;

    always_comb
    begin
        sx = ONE - {1'b0, s2_fx_reg};
        sy = ONE - {1'b0, s2_fy_reg};
        p_ul = sx * sy;
        p_ur = {1'b0, s2_fx_reg} * sy;
        p_bl = sx * {1'b0, s2_fy_reg};
        p_br = {1'b0, s2_fx_reg} * {1'b0, s2_fy_reg};
        base_full = s2_yi_reg * w_dim;
    end

    // stage 4 neighbor addresses, wrapped to the store size
    logic [AW-1:0] ul_next, ur_next, bl_next, br_next;

    always_comb
    begin
        ul_next = s3_base_reg + AW'(s3_xi_reg);
        ur_next = s3_hr_reg ? ul_next + AW'(1) : ul_next;
        bl_next = s3_hb_reg ? ul_next + AW'(w_dim) : ul_next;
        br_next = (s3_hr_reg && s3_hb_reg) ? ul_next + AW'(w_dim) + AW'(1) : ul_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
            s2_ctl_reg <= '0;
            s3_ctl_reg <= '0;
            s4_ctl_reg <= '0;
        end
        else if (adv)
        begin
            s1_ctl_reg <= in_ctl;
            s2_ctl_reg <= s1_ctl_reg;
            s3_ctl_reg <= s2_ctl_reg;
            s4_ctl_reg <= s3_ctl_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_idx_reg <= pixel_index;
            s1_val_reg <= pixel_value;
            s1_px_reg  <= dst_x * x_step;
            s1_py_reg  <= dst_y * y_step;

            s2_idx_reg <= s1_idx_reg;
            s2_val_reg <= s1_val_reg;
            s2_xi_reg  <= xi_next;
            s2_yi_reg  <= yi_next;
            s2_fx_reg  <= fx_next;
            s2_fy_reg  <= fy_next;
            s2_hr_reg  <= ({1'b0, xi_next} + (DW + 1)'(1)) < {1'b0, w_dim};
            s2_hb_reg  <= ({1'b0, yi_next} + (DW + 1)'(1)) < {1'b0, h_dim};

            s3_idx_reg  <= s2_idx_reg;
            s3_val_reg  <= s2_val_reg;
            s3_base_reg <= base_full[AW-1:0];
            s3_xi_reg   <= s2_xi_reg;
            s3_hr_reg   <= s2_hr_reg;
            s3_hb_reg   <= s2_hb_reg;
            s3_wul_reg  <= p_ul[WW-1:0];
            s3_wur_reg  <= p_ur[WW-1:0];
            s3_wbl_reg  <= p_bl[WW-1:0];
            s3_wbr_reg  <= p_br[WW-1:0];

            s4_idx_reg <= s3_idx_reg;
            s4_val_reg <= s3_val_reg;
            s4_ul_reg  <= ul_next;
            s4_ur_reg  <= ur_next;
            s4_bl_reg  <= bl_next;
            s4_br_reg  <= br_next;
            s4_wul_reg <= s3_wul_reg;
            s4_wur_reg <= s3_wur_reg;
            s4_wbl_reg <= s3_wbl_reg;
            s4_wbr_reg <= s3_wbr_reg;
        end
    end

    assign out_ctl = s4_ctl_reg;
    assign waddr   = s4_idx_reg;
    assign wdata   = s4_val_reg;
    assign a_ul    = s4_ul_reg;
    assign a_ur    = s4_ur_reg;
    assign a_bl    = s4_bl_reg;
    assign a_br    = s4_br_reg;
    assign w_ul    = s4_wul_reg;
    assign w_ur    = s4_wur_reg;
    assign w_bl    = s4_wbl_reg;
    assign w_br    = s4_wbr_reg;

endmodule

// File: src/bir_blend.sv
// per-channel weight multiply, sum and output register
module bir_blend #(
    parameter int FRAC_BITS = bir_pkg::DEF_FRAC_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  bir_pkg::bir_ctl_t         in_ctl,
    input  logic [2*FRAC_BITS:0]      w_ul,
    input  logic [2*FRAC_BITS:0]      w_ur,
    input  logic [2*FRAC_BITS:0]      w_bl,
    input  logic [2*FRAC_BITS:0]      w_br,
    input  logic [bir_pkg::PIX_W-1:0] d_ul,
    input  logic [bir_pkg::PIX_W-1:0] d_ur,
    input  logic [bir_pkg::PIX_W-1:0] d_bl,
    input  logic [bir_pkg::PIX_W-1:0] d_br,
    output logic                      out_valid,
    output logic [bir_pkg::PIX_W-1:0] pixel_out
);

    localparam int CW  = bir_pkg::CHAN_W;
    localparam int NC  = bir_pkg::NUM_CHAN;
    localparam int WW  = 2 * FRAC_BITS + 1;
    localparam int PW  = WW + CW;
    localparam int ACW = PW + 2;
    localparam int SH  = 2 * FRAC_BITS;

    bir_pkg::bir_ctl_t s5_ctl_reg, s6_ctl_reg;
    logic [WW-1:0] s5_wul_reg, s5_wur_reg, s5_wbl_reg, s5_wbr_reg;
    logic [PW-1:0] prod_next [NC][4];
    logic [PW-1:0] prod_reg  [NC][4];
    logic [bir_pkg::PIX_W-1:0] pix_next;
    logic [bir_pkg::PIX_W-1:0] pix_reg;
    logic out_valid_reg, out_valid_next;

    // store read data belongs to the item in stage 5
    always_comb
    begin
        for (int c = 0; c < NC; c++)
        begin
            prod_next[c][0] = PW'(d_ul[c*CW +: CW]) * PW'(s5_wul_reg);
            prod_next[c][1] = PW'(d_ur[c*CW +: CW]) * PW'(s5_wur_reg);
            prod_next[c][2] = PW'(d_bl[c*CW +: CW]) * PW'(s5_wbl_reg);
            prod_next[c][3] = PW'(d_br[c*CW +: CW]) * PW'(s5_wbr_reg);
        end
    end

    always_comb
    begin
        logic [ACW-1:0] acc;
        for (int c = 0; c < NC; c++)
        begin
            acc = ACW'(prod_reg[c][0]) + ACW'(prod_reg[c][1])
                + ACW'(prod_reg[c][2]) + ACW'(prod_reg[c][3]);
            if (acc[ACW-1:SH+CW] != '0)
                pix_next[c*CW +: CW] = '1;
            else
                pix_next[c*CW +: CW] = acc[SH +: CW];
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (adv)
            out_valid_next = s6_ctl_reg.valid && !s6_ctl_reg.wr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s5_ctl_reg    <= '0;
            s6_ctl_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (adv)
            begin
                s5_ctl_reg <= in_ctl;
                s6_ctl_reg <= s5_ctl_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s5_wul_reg <= w_ul;
            s5_wur_reg <= w_ur;
            s5_wbl_reg <= w_bl;
            s5_wbr_reg <= w_br;
            prod_reg   <= prod_next;
            pix_reg    <= pix_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel_out = pix_reg;

endmodule

// File: src/bilinear_image_resampler.sv
// top level of the bilinear image resampler
// a sample goes through the address stages, store read, products and the output register
// throughput: one item per cycle; the four neighbors come from four copies of the frame store
// a stall at the output holds the whole pipeline in place
// reset clears pipeline valid bits and loads the register defaults; store contents stay undefined
// a write item is in the store before any later sample reads it
module bilinear_image_resampler #(
    parameter int MAX_WIDTH  = bir_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bir_pkg::DEF_MAX_HEIGHT,
    parameter int FRAC_BITS  = bir_pkg::DEF_FRAC_BITS
) (
    input  logic                               clk,
    input  logic                               rst_n,
    bir_req_if.sink                            req,
    bir_rsp_if.source                          rsp,
    input  logic                               cfg_we,
    input  logic [bir_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bir_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int AW = bir_pkg::INDEX_W;
    localparam int WW = 2 * FRAC_BITS + 1;

    logic [bir_pkg::DIM_W-1:0]  src_width_reg, src_height_reg;
    logic [bir_pkg::STEP_W-1:0] x_step_reg, y_step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= bir_pkg::RST_SRC_WIDTH;
            src_height_reg <= bir_pkg::RST_SRC_HEIGHT;
            x_step_reg     <= bir_pkg::RST_STEP;
            y_step_reg     <= bir_pkg::RST_STEP;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bir_pkg::REG_SRC_WIDTH:  src_width_reg  <= cfg_data[bir_pkg::DIM_W-1:0];
                bir_pkg::REG_SRC_HEIGHT: src_height_reg <= cfg_data[bir_pkg::DIM_W-1:0];
                bir_pkg::REG_X_STEP:     x_step_reg     <= cfg_data;
                bir_pkg::REG_Y_STEP:     y_step_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    logic adv;
    logic out_valid;
    bir_pkg::bir_ctl_t in_ctl, s4_ctl;
    logic [AW-1:0] waddr, a_ul, a_ur, a_bl, a_br;
    logic [bir_pkg::PIX_W-1:0] wdata, d_ul, d_ur, d_bl, d_br;
    logic [WW-1:0] w_ul, w_ur, w_bl, w_br;
    logic st_we;

    // the pipeline moves whenever the output register is free or being taken
    assign adv       = !out_valid || rsp.ready;
    assign req.ready = adv;
    assign in_ctl.valid = req.valid;
    assign in_ctl.wr    = !req.func;
    assign st_we = adv && s4_ctl.valid && s4_ctl.wr;

    bir_addr #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .FRAC_BITS  (FRAC_BITS)
    ) u_addr (
        .clk         (clk),
        .rst_n       (rst_n),
        .adv         (adv),
        .in_ctl      (in_ctl),
        .pixel_index (req.pixel_index),
        .pixel_value (req.pixel_value),
        .dst_x       (req.dst_x),
        .dst_y       (req.dst_y),
        .src_width   (src_width_reg),
        .src_height  (src_height_reg),
        .x_step      (x_step_reg),
        .y_step      (y_step_reg),
        .out_ctl     (s4_ctl),
        .waddr       (waddr),
        .wdata       (wdata),
        .a_ul        (a_ul),
        .a_ur        (a_ur),
        .a_bl        (a_bl),
        .a_br        (a_br),
        .w_ul        (w_ul),
        .w_ur        (w_ur),
        .w_bl        (w_bl),
        .w_br        (w_br)
    );

    bir_ram #(.WIDTH(bir_pkg::PIX_W), .DEPTH(bir_pkg::STORE_DEPTH)) u_ram_ul (
        .clk (clk), .we (st_we), .waddr (waddr), .wdata (wdata),
        .re (adv), .raddr (a_ul), .rdata (d_ul)
    );

    bir_ram #(.WIDTH(bir_pkg::PIX_W), .DEPTH(bir_pkg::STORE_DEPTH)) u_ram_ur (
        .clk (clk), .we (st_we), .waddr (waddr), .wdata (wdata),
        .re (adv), .raddr (a_ur), .rdata (d_ur)
    );

    bir_ram #(.WIDTH(bir_pkg::PIX_W), .DEPTH(bir_pkg::STORE_DEPTH)) u_ram_bl (
        .clk (clk), .we (st_we), .waddr (waddr), .wdata (wdata),
        .re (adv), .raddr (a_bl), .rdata (d_bl)
    );

    bir_ram #(.WIDTH(bir_pkg::PIX_W), .DEPTH(bir_pkg::STORE_DEPTH)) u_ram_br (
        .clk (clk), .we (st_we), .waddr (waddr), .wdata (wdata),
        .re (adv), .raddr (a_br), .rdata (d_br)
    );

    bir_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_ctl    (s4_ctl),
        .w_ul      (w_ul),
        .w_ur      (w_ur),
        .w_bl      (w_bl),
        .w_br      (w_br),
        .d_ul      (d_ul),
        .d_ur      (d_ur),
        .d_bl      (d_bl),
        .d_br      (d_br),
        .out_valid (out_valid),
        .pixel_out (rsp.pixel_out)
    );

    assign rsp.valid = out_valid;

endmodule

// File: src/bir_checker.sv
// port-level checks of the resampler and their binding
module bir_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic [bir_pkg::PIX_W-1:0] pixel_out
);

    // a held result keeps its valid
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    // a held result keeps its value
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(pixel_out))
        else $error("result changed while stalled");

    // input is taken exactly when the output side can move
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready == (!out_valid || out_ready))
        else $error("input ready does not follow output side");

    // nothing comes out right after reset
    assert property (@(posedge clk)
        $rose(rst_n) |-> !out_valid)
        else $error("result present out of reset");

endmodule

bind bilinear_image_resampler bir_checker u_bir_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .pixel_out (rsp.pixel_out)
);

// File: tb/tb_bilinear_image_resampler.sv
// self-checking testbench for the bilinear image resampler
`timescale 1ns / 1ps

module tb_bilinear_image_resampler;

    localparam int PIPE_LAT = 7;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [bir_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [bir_pkg::CFG_DATA_W-1:0] cfg_data;

    bir_req_if req_ch ();
    bir_rsp_if rsp_ch ();

    bilinear_image_resampler i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch.sink),
        .rsp       (rsp_ch.source),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // predictor state
    logic [bir_pkg::PIX_W-1:0] frame_copy [bir_pkg::STORE_DEPTH];
    bit               written [bir_pkg::STORE_DEPTH];
    logic [bir_pkg::DIM_W-1:0]  width_reg;
    logic [bir_pkg::DIM_W-1:0]  height_reg;
    logic [bir_pkg::STEP_W-1:0] xstep_reg;
    logic [bir_pkg::STEP_W-1:0] ystep_reg;

    logic [bir_pkg::PIX_W-1:0] expected_pixels [$];
    int  error_count;
    bit  hold_off_req;
    int  hold_off_cycles;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    function automatic int eff_dim(logic [bir_pkg::DIM_W-1:0] v);
        if (v == 0) return 1;
        if (v > 256) return 256;
        return int'(v);
    endfunction

    function automatic void split_position(logic [bir_pkg::POS_W-1:0] pos, int dim,
                                           output int ip, output int fr);
        if ((pos >> bir_pkg::POS_FRAC) >= dim - 1)
        begin
            ip = dim - 1;
            fr = 0;
        end
        else
        begin
            ip = int'(pos >> bir_pkg::POS_FRAC);
            fr = int'((pos >> 8) & 8'hFF);
        end
    endfunction

    function automatic logic [bir_pkg::PIX_W-1:0] store_at(int row, int col, int w);
        logic [15:0] a;
        a = 16'(row * w + col);
        return frame_copy[a];
    endfunction

    function automatic logic [bir_pkg::PIX_W-1:0] blend_sample(
        logic [bir_pkg::COORD_W-1:0] x, logic [bir_pkg::COORD_W-1:0] y);
        int w, h, xi, yi, fx, fy;
        logic [bir_pkg::PIX_W-1:0] ul, ur, bl, br, res;
        longint acc;
        longint wul, wur, wbl, wbr;
        w = eff_dim(width_reg);
        h = eff_dim(height_reg);
        split_position(bir_pkg::POS_W'(x) * bir_pkg::POS_W'(xstep_reg), w, xi, fx);
        split_position(bir_pkg::POS_W'(y) * bir_pkg::POS_W'(ystep_reg), h, yi, fy);
        ul = store_at(yi, xi, w);
        ur = (xi + 1 < w) ? store_at(yi, xi + 1, w) : ul;
        bl = (yi + 1 < h) ? store_at(yi + 1, xi, w) : ul;
        br = (xi + 1 < w && yi + 1 < h) ? store_at(yi + 1, xi + 1, w) : ul;
        wul = (256 - fx) * (256 - fy);
        wur = fx * (256 - fy);
        wbl = (256 - fx) * fy;
        wbr = fx * fy;
        for (int c = 0; c < bir_pkg::NUM_CHAN; c++)
        begin
            acc = ul[c*8 +: 8] * wul + ur[c*8 +: 8] * wur
                + bl[c*8 +: 8] * wbl + br[c*8 +: 8] * wbr;
            acc = acc >> 16;
            res[c*8 +: 8] = (acc > 255) ? 8'hFF : acc[7:0];
        end
        return res;
    endfunction

    // every neighbour a sample could touch must have been written
    function automatic bit sample_is_safe(logic [bir_pkg::COORD_W-1:0] x,
                                          logic [bir_pkg::COORD_W-1:0] y);
        int w, h, xi, yi, fx, fy;
        w = eff_dim(width_reg);
        h = eff_dim(height_reg);
        split_position(bir_pkg::POS_W'(x) * bir_pkg::POS_W'(xstep_reg), w, xi, fx);
        split_position(bir_pkg::POS_W'(y) * bir_pkg::POS_W'(ystep_reg), h, yi, fy);
        for (int dy = 0; dy < 2; dy++)
            for (int dx = 0; dx < 2; dx++)
                if (xi + dx < w && yi + dy < h)
                    if (!written[16'((yi + dy) * w + xi + dx)]) return 0;
        return 1;
    endfunction

    // valid stays high after an accept until the next item or an idle phase replaces it
    task automatic send_item(bit f, logic [bir_pkg::INDEX_W-1:0] idx,
                             logic [bir_pkg::PIX_W-1:0] val,
                             logic [bir_pkg::COORD_W-1:0] x,
                             logic [bir_pkg::COORD_W-1:0] y);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.func        <= f;
        req_ch.pixel_index <= idx;
        req_ch.pixel_value <= val;
        req_ch.dst_x       <= x;
        req_ch.dst_y       <= y;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        if (f)
            expected_pixels.push_back(blend_sample(x, y));
        else
        begin
            frame_copy[idx] = val;
            written[idx] = 1'b1;
        end
    endtask

    task automatic idle_input();
        req_ch.valid <= 1'b0;
    endtask

    task automatic write_pixel(logic [bir_pkg::INDEX_W-1:0] idx, logic [bir_pkg::PIX_W-1:0] val);
        send_item(1'b0, idx, val, bir_pkg::COORD_W'($urandom), bir_pkg::COORD_W'($urandom));
    endtask

    task automatic sample_pixel(logic [bir_pkg::COORD_W-1:0] x, logic [bir_pkg::COORD_W-1:0] y);
        if (sample_is_safe(x, y))
            send_item(1'b1, bir_pkg::INDEX_W'($urandom), $urandom, x, y);
    endtask

    task automatic drain_results();
        idle_input();
        while (expected_pixels.size() != 0) @(posedge clk);
        repeat (PIPE_LAT + 3) @(posedge clk);
    endtask

    task automatic write_register(logic [bir_pkg::CFG_IDX_W-1:0] idx,
                                  logic [bir_pkg::CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            bir_pkg::REG_SRC_WIDTH:  width_reg  = val[bir_pkg::DIM_W-1:0];
            bir_pkg::REG_SRC_HEIGHT: height_reg = val[bir_pkg::DIM_W-1:0];
            bir_pkg::REG_X_STEP:     xstep_reg  = val;
            bir_pkg::REG_Y_STEP:     ystep_reg  = val;
            default: ;
        endcase
    endtask

    task automatic set_geometry(int w, int h, int xs, int ys);
        drain_results();
        write_register(bir_pkg::REG_SRC_WIDTH, bir_pkg::CFG_DATA_W'(w));
        write_register(bir_pkg::REG_SRC_HEIGHT, bir_pkg::CFG_DATA_W'(h));
        write_register(bir_pkg::REG_X_STEP, bir_pkg::CFG_DATA_W'(xs));
        write_register(bir_pkg::REG_Y_STEP, bir_pkg::CFG_DATA_W'(ys));
        cfg_we <= 1'b0;
    endtask

    task automatic fill_frame(int count);
        for (int i = 0; i < count; i++)
            write_pixel(bir_pkg::INDEX_W'(i), $urandom);
    endtask

    task automatic test_directed();
        set_geometry(4, 3, 32768, 16384);
        write_pixel(0, 32'h0000_0000);
        write_pixel(1, 32'hFFFF_FFFF);
        write_pixel(2, 32'h80FF_007F);
        write_pixel(3, 32'h0102_0304);
        for (int i = 4; i < 12; i++) write_pixel(bir_pkg::INDEX_W'(i), $urandom);
        write_pixel(16'hFFFF, 32'hDEAD_BEEF);
        sample_pixel(0, 0);
        sample_pixel(1, 1);
        sample_pixel(5, 7);
        sample_pixel(12'hFFF, 12'hFFF);
        sample_pixel(7, 12'hFFF);
        // zero width and height act as one pixel
        set_geometry(0, 0, 24'hFFFFFF, 24'hFFFFFF);
        sample_pixel(0, 0);
        sample_pixel(12'hFFF, 12'h123);
        // oversize dims clamp to the maximum; zero step pins the origin
        set_geometry(511, 300, 0, 0);
        sample_pixel(12'hFFF, 12'hFFF);
        set_geometry(2, 2, 24'h00FF00, 24'h00FF00);
        sample_pixel(1, 1);
        sample_pixel(0, 1);
    endtask

    task automatic test_random(int n);
        int w, h;
        for (int i = 0; i < n; i++)
        begin
            if (i % 300 == 0)
            begin
                w = ($urandom_range(0, 9) == 0) ? 256 : $urandom_range(1, 20);
                h = ($urandom_range(0, 9) == 0) ? 256 : $urandom_range(1, 20);
                set_geometry(w, h, $urandom_range(0, 24'h03FFFF), $urandom_range(0, 24'h03FFFF));
                if (w * h > 400) set_geometry(w, h, $urandom, $urandom);
                fill_frame((w * h > 400) ? 0 : w * h);
            end
            if ($urandom_range(0, 3) == 0)
                write_pixel(bir_pkg::INDEX_W'($urandom_range(0, 399)), $urandom);
            else if (w * h > 400)
            begin
                // large frame: write the four neighbours just before sampling
                sample_big_frame();
            end
            else
                sample_pixel(bir_pkg::COORD_W'($urandom_range(0, 63)),
                             bir_pkg::COORD_W'($urandom_range(0, 63)));
        end
    endtask

    task automatic sample_big_frame();
        logic [bir_pkg::COORD_W-1:0] x, y;
        int w, h, xi, yi, fx, fy;
        x = bir_pkg::COORD_W'($urandom);
        y = bir_pkg::COORD_W'($urandom);
        w = eff_dim(width_reg);
        h = eff_dim(height_reg);
        split_position(bir_pkg::POS_W'(x) * bir_pkg::POS_W'(xstep_reg), w, xi, fx);
        split_position(bir_pkg::POS_W'(y) * bir_pkg::POS_W'(ystep_reg), h, yi, fy);
        for (int dy = 0; dy < 2; dy++)
            for (int dx = 0; dx < 2; dx++)
                if (xi + dx < w && yi + dy < h)
                    write_pixel(16'((yi + dy) * w + xi + dx), $urandom);
        sample_pixel(x, y);
    endtask

    task automatic test_backpressure();
        set_geometry(8, 8, 24'h00C000, 24'h00A000);
        fill_frame(64);
        hold_off_cycles = 60;
        hold_off_req = 1'b1;
        for (int i = 0; i < 40; i++)
            send_item(1'b1, '0, '0, bir_pkg::COORD_W'($urandom_range(0, 15)),
                      bir_pkg::COORD_W'($urandom_range(0, 15)));
        // pause until everything has come out
        idle_input();
        while (expected_pixels.size() != 0) @(posedge clk);
        for (int i = 0; i < 20; i++)
            sample_pixel(bir_pkg::COORD_W'($urandom_range(0, 15)),
                         bir_pkg::COORD_W'($urandom_range(0, 15)));
    endtask

    // receiver: random stalls plus a long hold-off on request
    initial
    begin
        int g;
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (hold_off_cycles) @(posedge clk);
            end
            g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
            if (g > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (g) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        logic [bir_pkg::PIX_W-1:0] exp_px;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_pixels.size() == 0)
            begin
                $display("%0t: unexpected result expected none actual %h", $time,
                         rsp_ch.pixel_out);
                error_count++;
            end
            else
            begin
                exp_px = expected_pixels.pop_front();
                if (rsp_ch.pixel_out !== exp_px)
                begin
                    $display("%0t: pixel_out mismatch expected %h actual %h", $time,
                             exp_px, rsp_ch.pixel_out);
                    error_count++;
                end
            end
        end
    end

    initial
    begin
        error_count = 0;
        hold_off_req = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.func = 1'b0;
        req_ch.pixel_index = '0;
        req_ch.pixel_value = '0;
        req_ch.dst_x = '0;
        req_ch.dst_y = '0;
        width_reg = bir_pkg::RST_SRC_WIDTH;
        height_reg = bir_pkg::RST_SRC_HEIGHT;
        xstep_reg = bir_pkg::RST_STEP;
        ystep_reg = bir_pkg::RST_STEP;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_random(960);
        drain_results();
        if (error_count == 0 && expected_pixels.size() == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
